### src/assert_macros.svh
// Assertion macros shared by the RTL of the hash table engine.
// Needs clk and rst (synchronous, active high) in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition c holds in the same cycle as a.
`define CHTE_ASSERT_SAME(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Condition c holds in the cycle after a.
`define CHTE_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### src/chte_pkg.sv
// Package of the chained hash table engine: defaults, op and status codes.
// No dependencies.
package chte_pkg;

  localparam int BUCKETS_DEF       = 256;
  localparam int NODES_DEF         = 1024;
  localparam int KEY_BYTES_MAX_DEF = 8;
  localparam int VALUE_BITS_DEF    = 32;

  localparam logic [63:0] HASH_SEED = 64'd5381;
  localparam int          HASH_SHIFT = 5;

  localparam logic [8:0] BUCKET_COUNT_RST = 9'd256;
  localparam logic [3:0] KEY_BYTES_RST    = 4'd8;

  localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;
  localparam logic [0:0] REG_KEY_BYTES    = 1'b1;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

endpackage

### src/chte_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module chte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/chained_hash_table_engine.sv
// Chained hash table engine: insert/update, delete and search on keys of
// key_bytes bytes, hashed with 64-bit djb2 and reduced modulo bucket_count.
// One operation at a time; the hash takes one byte a cycle, the modulo
// four quotient bits at a time, and each chain node one read of node
// memory. After reset a clearing pass empties the bucket heads and the
// free-node bitmap before the first transfer.
// Depends on chte_pkg, chte_ram and assert_macros.svh.
`include "assert_macros.svh"

module chained_hash_table_engine #(
  parameter int BUCKETS       = chte_pkg::BUCKETS_DEF,
  parameter int NODES         = chte_pkg::NODES_DEF,
  parameter int KEY_BYTES_MAX = chte_pkg::KEY_BYTES_MAX_DEF,
  parameter int VALUE_BITS    = chte_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [1:0]  status,
  output logic [31:0] found_value
);
  import chte_pkg::*;

  localparam int BAW   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int BCW   = $clog2(BUCKETS + 1);
  localparam int CW    = BCW > 9 ? BCW : 9;
  localparam int NW    = $clog2(NODES + 1);
  localparam int NAW   = $clog2(NODES);
  localparam int WORDS = (NODES + 31) / 32;
  localparam int WAW   = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int CLRN  = BUCKETS > WORDS ? BUCKETS : WORDS;
  localparam int CLW   = $clog2(CLRN + 1);
  localparam int KVW   = 64 + VALUE_BITS;
  localparam logic [NW-1:0] NIL = NW'(NODES);
  localparam logic [31:0] PAD = ~32'd0 << (NODES - 32 * (WORDS - 1));

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_DIV, S_HEAD_RD, S_HEAD_WAIT, S_WALK,
    S_NODE_WAIT, S_RESOLVE, S_BM_WAIT, S_FINISH
  } state_t;

  state_t state;

  logic [8:0]  bucket_count;
  logic [3:0]  key_bytes;

  logic [1:0]            op_r;
  logic [63:0]           key_r;
  logic [63:0]           km_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [2:0]            kb_last;
  logic [2:0]            byte_idx;
  logic [BCW-1:0]        bc_r;
  logic [63:0]           h;
  logic [3:0]            div_cnt;
  logic [BCW-1:0]        rem;
  logic [BAW-1:0]        bkt;
  logic [NW-1:0]         head_r;
  logic [NW-1:0]         cur;
  logic [NW-1:0]         prev;
  logic [NW-1:0]         hit_next;
  logic [63:0]           hit_key;
  logic [VALUE_BITS-1:0] hit_val;
  logic                  hit;
  logic [WAW-1:0]        bm_word;
  logic                  bm_insert;
  logic [WORDS-1:0]      word_full;
  logic [CLW-1:0]        clr;
  logic                  res_ok;
  logic [1:0]            res_status;
  logic [31:0]           res_found;

  // Memory ports
  logic            head_we;
  logic [BAW-1:0]  head_waddr, head_raddr;
  logic [NW-1:0]   head_wdata, head_rdata;
  logic            kv_we;
  logic [NAW-1:0]  kv_waddr, kv_raddr;
  logic [KVW-1:0]  kv_wdata, kv_rdata;
  logic            nx_we;
  logic [NAW-1:0]  nx_waddr;
  logic [NW-1:0]   nx_wdata, nx_rdata;
  logic            bm_we;
  logic [WAW-1:0]  bm_waddr, bm_raddr;
  logic [31:0]     bm_wdata, bm_rdata;

  // Decode of the current configuration
  logic [3:0]     kb_eff;
  logic [63:0]    km;
  logic [CW-1:0]  bc_ext;
  logic [BCW-1:0] bc_eff;

  always_comb begin
    kb_eff = key_bytes;
    if (kb_eff == 4'd0) begin
      kb_eff = 4'd1;
    end
    if (kb_eff > 4'(KEY_BYTES_MAX)) begin
      kb_eff = 4'(KEY_BYTES_MAX);
    end
    km = (kb_eff >= 4'd8) ? ~64'd0 : ((64'd1 << {kb_eff, 3'b000}) - 64'd1);
    bc_ext = CW'(bucket_count);
    if (bc_ext == '0) begin
      bc_ext = CW'(1);
    end
    if (bc_ext > CW'(BUCKETS)) begin
      bc_ext = CW'(BUCKETS);
    end
    bc_eff = BCW'(bc_ext);
  end

  // Hash step and four-bit remainder step
  logic [7:0]     key_byte;
  logic [63:0]    h_step;
  logic [BCW-1:0] rem_next;
  logic [BCW:0]   trial;

  always_comb begin
    key_byte = 8'(key_r >> {byte_idx, 3'b000});
    h_step   = (h << HASH_SHIFT) + h + 64'(key_byte);
    rem_next = rem;
    for (int k = 0; k < 4; k++) begin
      trial = {rem_next, h[63 - k]};
      if (trial >= {1'b0, bc_r}) begin
        trial = trial - {1'b0, bc_r};
      end
      rem_next = BCW'(trial);
    end
  end

  // Lowest free word and lowest free bit
  logic           any_free;
  logic [WAW-1:0] free_word;
  logic [4:0]     free_bit;
  logic [NW-1:0]  free_node;

  always_comb begin
    any_free  = 1'b0;
    free_word = '0;
    for (int w = WORDS - 1; w >= 0; w--) begin
      if (!word_full[w]) begin
        any_free  = 1'b1;
        free_word = WAW'(w);
      end
    end
    free_bit = '0;
    for (int b = 31; b >= 0; b--) begin
      if (!bm_rdata[b]) begin
        free_bit = 5'(b);
      end
    end
    free_node = NW'({bm_word, free_bit});
  end

  logic key_match;
  assign key_match = ((kv_rdata[KVW-1 -: 64] & km_r) == key_r);

  // Memory control
  always_comb begin
    head_we    = 1'b0;
    head_waddr = bkt;
    head_wdata = NIL;
    head_raddr = bkt;
    kv_we      = 1'b0;
    kv_waddr   = NAW'(cur);
    kv_wdata   = {hit_key, val_r};
    kv_raddr   = NAW'(cur);
    nx_we      = 1'b0;
    nx_waddr   = NAW'(prev);
    nx_wdata   = hit_next;
    bm_we      = 1'b0;
    bm_waddr   = bm_word;
    bm_wdata   = bm_rdata;
    bm_raddr   = bm_word;
    unique case (state)
      S_CLEAR: begin
        head_we    = (clr < CLW'(BUCKETS));
        head_waddr = BAW'(clr);
        bm_we      = (clr < CLW'(WORDS));
        bm_waddr   = WAW'(clr);
        bm_wdata   = (clr == CLW'(WORDS - 1)) ? PAD : 32'd0;
      end
      S_RESOLVE: begin
        if (op_r == OP_INSERT) begin
          kv_we    = hit;
          bm_raddr = free_word;
        end else if (op_r == OP_DELETE && hit) begin
          head_we    = (prev == NIL);
          head_wdata = hit_next;
          nx_we      = (prev != NIL);
          bm_raddr   = WAW'(cur >> 5);
        end
      end
      S_BM_WAIT: begin
        bm_we = 1'b1;
        if (bm_insert) begin
          bm_wdata   = bm_rdata | (32'd1 << free_bit);
          head_we    = 1'b1;
          head_wdata = free_node;
          kv_we      = 1'b1;
          kv_waddr   = NAW'(free_node);
          kv_wdata   = {key_r, val_r};
          nx_we      = 1'b1;
          nx_waddr   = NAW'(free_node);
          nx_wdata   = head_r;
        end else begin
          bm_wdata = bm_rdata & ~(32'd1 << 5'(cur));
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      word_full    <= '0;
      bucket_count <= BUCKET_COUNT_RST;
      key_bytes    <= KEY_BYTES_RST;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BUCKET_COUNT: bucket_count <= cfg_data;
          REG_KEY_BYTES:    key_bytes    <= cfg_data[3:0];
        endcase
      end
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + CLW'(1);
          if (clr == CLW'(CLRN - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= op;
            key_r    <= key & km;
            km_r     <= km;
            val_r    <= VALUE_BITS'(value);
            kb_last  <= 3'(kb_eff - 4'd1);
            byte_idx <= '0;
            bc_r     <= bc_eff;
            h        <= HASH_SEED;
            state    <= S_HASH;
          end
        end
        S_HASH: begin
          h        <= h_step;
          byte_idx <= byte_idx + 3'd1;
          if (byte_idx == kb_last) begin
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          h       <= h << 4;
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) begin
            bkt   <= BAW'(rem_next);
            state <= S_HEAD_RD;
          end
        end
        S_HEAD_RD: begin
          state <= S_HEAD_WAIT;
        end
        S_HEAD_WAIT: begin
          head_r <= head_rdata;
          cur    <= head_rdata;
          prev   <= NIL;
          state  <= S_WALK;
        end
        S_WALK: begin
          if (cur == NIL) begin
            hit   <= 1'b0;
            state <= S_RESOLVE;
          end else begin
            state <= S_NODE_WAIT;
          end
        end
        S_NODE_WAIT: begin
          if (key_match) begin
            hit      <= 1'b1;
            hit_key  <= kv_rdata[KVW-1 -: 64];
            hit_val  <= kv_rdata[VALUE_BITS-1:0];
            hit_next <= nx_rdata;
            state    <= S_RESOLVE;
          end else begin
            prev  <= cur;
            cur   <= nx_rdata;
            state <= S_WALK;
          end
        end
        S_RESOLVE: begin
          res_ok     <= hit;
          res_status <= hit ? ST_DONE : ST_NOT_FOUND;
          res_found  <= '0;
          state      <= S_FINISH;
          if (op_r == OP_INSERT) begin
            if (!hit) begin
              if (any_free) begin
                bm_word   <= free_word;
                bm_insert <= 1'b1;
                res_ok     <= 1'b1;
                res_status <= ST_DONE;
                state     <= S_BM_WAIT;
              end else begin
                res_status <= ST_FULL;
              end
            end
          end else if (op_r == OP_DELETE) begin
            if (hit) begin
              bm_word   <= WAW'(cur >> 5);
              bm_insert <= 1'b0;
              state     <= S_BM_WAIT;
            end
          end else begin
            if (hit) begin
              res_found <= 32'(hit_val);
            end
          end
        end
        S_BM_WAIT: begin
          if (bm_insert) begin
            word_full[bm_word] <= &(bm_rdata | (32'd1 << free_bit));
          end else begin
            word_full[bm_word] <= 1'b0;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            ok          <= res_ok;
            status      <= res_status;
            found_value <= res_found;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  chte_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  chte_ram #(.WIDTH(KVW), .DEPTH(NODES)) u_node_kv (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(kv_wdata),
    .raddr(kv_raddr), .rdata(kv_rdata)
  );

  chte_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(kv_raddr), .rdata(nx_rdata)
  );

  chte_ram #(.WIDTH(32), .DEPTH(WORDS)) u_free_map (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  `CHTE_ASSERT_SAME(a_ok_status, out_valid, ok == (status == ST_DONE))
  `CHTE_ASSERT_SAME(a_found_needs_ok, out_valid && found_value != 32'd0, ok)
  `CHTE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `CHTE_ASSERT_SAME(a_walk_in_range, state == S_NODE_WAIT, cur < NIL)

endmodule
